>>> rtl/arcsin_series_unit_core_defines.svh
// Assertion macros for the arcsine series unit checker.
// Used by asu_checker.sv; expects clk and rst in scope at the point of use.
`ifndef ARCSIN_SERIES_UNIT_CORE_DEFINES_SVH
`define ARCSIN_SERIES_UNIT_CORE_DEFINES_SVH

// same-cycle implication, quiet while reset is high
`define ASU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("asu check failed");

// next-cycle implication, quiet while reset is high
`define ASU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("asu check failed");

`endif

>>> rtl/asu_pkg.sv
// Shared types, constants and the constant-divisor digit step for the
// arcsine series unit. No dependencies.
`default_nettype none

package asu_pkg;

  localparam int TERM_COUNT = 6;
  localparam int MAX_TERMS  = 8;

  localparam int X_W   = 16;  // Q2.14 argument and result
  localparam int U_W   = 14;  // |x| below 1.0, Q0.14
  localparam int U2_W  = 28;  // u*u, Q0.28
  localparam int P_W   = 50;  // odd powers, Q0.50
  localparam int SUM_W = 51;  // running sum stays below pi/2
  localparam int N_W   = 60;  // scaled power fed to the divider, three digits
  localparam int DIG_W = 20;  // divider digit
  localparam int REM_W = 4;   // remainder, odd divisors up to 13
  localparam int MAG_W = 15;  // result magnitude

  localparam logic signed [X_W-1:0] ONE_Q14     = 16'sd16384;
  localparam logic        [MAG_W-1:0] HALF_PI_Q14 = 15'd25736;

  // coefficient a/b written as a / (2^shift * div), div odd
  typedef struct packed {
    logic [7:0]  num;
    logic [3:0]  shift;
    logic [3:0]  div;
    logic [28:0] recip;  // floor(2^28 / div)
  } coef_t;

  localparam coef_t COEF_TABLE [MAX_TERMS] = '{
    '{num: 8'd1,   shift: 4'd0,  div: 4'd1,  recip: 29'd268435456},  // 1
    '{num: 8'd1,   shift: 4'd1,  div: 4'd3,  recip: 29'd89478485},   // 1/6
    '{num: 8'd3,   shift: 4'd3,  div: 4'd5,  recip: 29'd53687091},   // 3/40
    '{num: 8'd5,   shift: 4'd4,  div: 4'd7,  recip: 29'd38347922},   // 5/112
    '{num: 8'd35,  shift: 4'd7,  div: 4'd9,  recip: 29'd29826161},   // 35/1152
    '{num: 8'd63,  shift: 4'd8,  div: 4'd11, recip: 29'd24403223},   // 63/2816
    '{num: 8'd231, shift: 4'd10, div: 4'd13, recip: 29'd20648881},   // 231/13312
    '{num: 8'd143, shift: 4'd11, div: 4'd5,  recip: 29'd53687091}    // 143/10240
  };

  typedef struct packed {
    logic valid;
    logic neg;
    logic sat;
  } ctl_t;

  typedef struct packed {
    logic [DIG_W-1:0] q;
    logic [REM_W-1:0] r;
  } div_res_t;

  // one 20-bit digit of long division by a small odd constant:
  // reciprocal estimate is low by at most one, then a single correction
  function automatic div_res_t div_digit(input logic [DIG_W+REM_W-1:0] v,
                                         input coef_t c);
    logic [52:0]             prod;
    logic [DIG_W-1:0]        q;
    logic [DIG_W+REM_W-1:0]  rem;
    div_res_t                res;
    prod = 53'(v) * 53'(c.recip);
    q    = prod[47:28];
    rem  = v - 24'({4'b0, q} * {20'b0, c.div});
    if (rem >= {20'b0, c.div}) begin
      q   = q + 20'd1;
      rem = rem - {20'b0, c.div};
    end
    res.q = q;
    res.r = rem[REM_W-1:0];
    return res;
  endfunction

endpackage

`default_nettype wire

>>> rtl/arcsin_series_unit_core.sv
// Arcsine of a Q2.14 argument by a Maclaurin series; top level.
// Depends on asu_pkg, asu_term_step and asu_out_buf.
//
// Usage:
//   Input channel  in_valid / in_ready, payload angle_sine (signed Q2.14).
//   Output channel out_valid / out_ready, payload angle (signed Q2.14 rad).
//   Arguments at or beyond +-1.0 give +-pi/2 (+-25736).
//   Throughput: one beat per clock on both channels while out_ready stays high.
//   Pipeline from the input beat to angle being shown: two front stages,
//   four per series term (set by the three-digit constant divider of each
//   term), two for the final sum and rounding, and the output register.
//   Reset (rst, synchronous) clears every valid bit; no beat is in flight
//   afterwards. in_ready is already high from the first clock edge in reset,
//   so in_valid must stay low until rst drops.
//   If the receiver stalls, the held result sits in the output register and
//   the next one goes to a single skid entry; once that is full in_ready
//   falls and the whole pipeline freezes in place until out_ready returns.
//   in_ready is registered and does not depend on out_ready in the same cycle.
`default_nettype none

module arcsin_series_unit_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic signed [asu_pkg::X_W-1:0] angle_sine,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [asu_pkg::X_W-1:0]      angle
);
  import asu_pkg::*;

  logic en;

  ctl_t              ctl_f1, ctl_f2, ctl_r1, ctl_r2;
  logic [U_W-1:0]    u_f1;
  logic [U2_W-1:0]   u2_f2;
  logic [P_W-1:0]    p0_f2;
  logic [X_W-1:0]    x_abs;
  logic              x_sat;

  ctl_t              ctl_chain [TERM_COUNT+1];
  logic [P_W-1:0]    p_chain   [TERM_COUNT+1];
  logic [U2_W-1:0]   u2_chain  [TERM_COUNT+1];
  logic [SUM_W-1:0]  sum_chain [TERM_COUNT+1];
  logic [P_W-1:0]    t_chain   [TERM_COUNT+1];

  logic [SUM_W-1:0]  sum_r1;
  logic [SUM_W:0]    rnd;
  logic [MAG_W-1:0]  mag_r2;
  logic [X_W-1:0]    mag_ext;
  logic signed [X_W-1:0] angle_next;
  logic              buf_ready;

  assign en       = buf_ready;
  assign in_ready = en;

  assign x_sat = (angle_sine >= ONE_Q14) || (angle_sine <= -ONE_Q14);
  assign x_abs = angle_sine[X_W-1] ? X_W'(-angle_sine) : X_W'(angle_sine);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_f1 <= '0;
      ctl_f2 <= '0;
      ctl_r1 <= '0;
      ctl_r2 <= '0;
    end else if (en) begin
      ctl_f1 <= '{valid: in_valid, neg: angle_sine[X_W-1], sat: x_sat};
      ctl_f2 <= ctl_f1;
      ctl_r1 <= ctl_chain[TERM_COUNT];
      ctl_r2 <= ctl_r1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_f1  <= x_abs[U_W-1:0];
      u2_f2 <= U2_W'(u_f1) * U2_W'(u_f1);
      p0_f2 <= {u_f1, {(P_W-U_W){1'b0}}};
    end
  end

  assign ctl_chain[0] = ctl_f2;
  assign p_chain[0]   = p0_f2;
  assign u2_chain[0]  = u2_f2;
  assign sum_chain[0] = '0;
  assign t_chain[0]   = '0;

  for (genvar n = 0; n < TERM_COUNT; n++) begin : g_term
    asu_term_step u_step (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .coef    (COEF_TABLE[n]),
      .ctl_in  (ctl_chain[n]),
      .p_in    (p_chain[n]),
      .u2_in   (u2_chain[n]),
      .sum_in  (sum_chain[n]),
      .t_in    (t_chain[n]),
      .ctl_out (ctl_chain[n+1]),
      .p_out   (p_chain[n+1]),
      .u2_out  (u2_chain[n+1]),
      .sum_out (sum_chain[n+1]),
      .t_out   (t_chain[n+1])
    );
  end

  // round to nearest, ties up in magnitude
  assign rnd = (SUM_W+1)'(sum_r1) + ((SUM_W+1)'(1) << (P_W - U_W - 1));

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r1 <= sum_chain[TERM_COUNT] + SUM_W'(t_chain[TERM_COUNT]);
      if (ctl_r1.sat || (rnd[SUM_W:P_W-U_W] > (SUM_W+1-P_W+U_W)'(HALF_PI_Q14))) begin
        mag_r2 <= HALF_PI_Q14;
      end else begin
        mag_r2 <= rnd[P_W-U_W+MAG_W-1:P_W-U_W];
      end
    end
  end

  assign mag_ext    = {1'b0, mag_r2};
  assign angle_next = ctl_r2.neg ? X_W'(-mag_ext) : mag_ext;

  asu_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (ctl_r2.valid && en),
    .up_angle  (angle_next),
    .up_ready  (buf_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .angle     (angle)
  );

endmodule

`default_nettype wire

>>> rtl/asu_out_buf.sv
// Output register plus one skid entry for the arcsine series unit.
// Depends on asu_pkg for widths; the ready it returns upstream is registered.
`default_nettype none

module asu_out_buf (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         up_valid,
  input  wire logic signed [asu_pkg::X_W-1:0] up_angle,
  output logic                              up_ready,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [asu_pkg::X_W-1:0]    angle
);
  import asu_pkg::*;

  logic                   skid_valid;
  logic signed [X_W-1:0]  skid_angle;
  logic                   up_beat;

  assign up_ready = !skid_valid;
  assign up_beat  = up_valid && up_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid  <= skid_valid || up_beat;
      skid_valid <= 1'b0;
    end else if (up_beat) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      angle <= skid_valid ? skid_angle : up_angle;
    end else if (up_beat) begin
      skid_angle <= up_angle;
    end
  end

endmodule

`default_nettype wire

>>> rtl/asu_term_step.sv
// One series term: four pipeline stages that add the previous term into the
// running sum, form the next odd power and divide this term by its constant.
// Depends on asu_pkg (coef_t, ctl_t, div_digit).
`default_nettype none

module asu_term_step (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         en,
  input  wire asu_pkg::coef_t               coef,
  input  wire asu_pkg::ctl_t                ctl_in,
  input  wire logic [asu_pkg::P_W-1:0]      p_in,
  input  wire logic [asu_pkg::U2_W-1:0]     u2_in,
  input  wire logic [asu_pkg::SUM_W-1:0]    sum_in,
  input  wire logic [asu_pkg::P_W-1:0]      t_in,
  output asu_pkg::ctl_t                     ctl_out,
  output logic [asu_pkg::P_W-1:0]           p_out,
  output logic [asu_pkg::U2_W-1:0]          u2_out,
  output logic [asu_pkg::SUM_W-1:0]         sum_out,
  output logic [asu_pkg::P_W-1:0]           t_out
);
  import asu_pkg::*;

  localparam int HALF_W = P_W / 2;
  localparam int PP_W   = HALF_W + U2_W;
  localparam int FULL_W = P_W + U2_W;

  ctl_t ctl1, ctl2, ctl3;

  logic [SUM_W-1:0]  sum1, sum2, sum3;
  logic [U2_W-1:0]   u2_1, u2_2, u2_3;
  logic [PP_W-1:0]   pw_hi, pw_lo;
  logic [P_W-1:0]    p2, p3;
  logic [N_W-1:0]    n1;
  logic [57:0]       n_prod;
  logic [2*DIG_W-1:0] n_lo2;
  logic [DIG_W-1:0]   n_lo3;
  logic [DIG_W-1:0]   q2_2, q2_3, q1_3;
  logic [REM_W-1:0]   r2, r3;
  logic [FULL_W-1:0]  pw_full;
  div_res_t           d2, d1, d0;
  logic [3*DIG_W-1:0] quot;

  assign n_prod  = 58'(p_in) * 58'(coef.num);
  assign pw_full = {pw_hi, {HALF_W{1'b0}}} + FULL_W'(pw_lo);

  // digits of the scaled power, most significant first
  assign d2   = div_digit({{REM_W{1'b0}}, n1[N_W-1 -: DIG_W]}, coef);
  assign d1   = div_digit({r2, n_lo2[2*DIG_W-1 -: DIG_W]}, coef);
  assign d0   = div_digit({r3, n_lo3}, coef);
  assign quot = {q2_3, q1_3, d0.q};

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1    <= '0;
      ctl2    <= '0;
      ctl3    <= '0;
      ctl_out <= '0;
    end else if (en) begin
      ctl1    <= ctl_in;
      ctl2    <= ctl1;
      ctl3    <= ctl2;
      ctl_out <= ctl3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: sum in, power partial products, scaled numerator
      sum1  <= sum_in + SUM_W'(t_in);
      u2_1  <= u2_in;
      pw_hi <= PP_W'(p_in[P_W-1:HALF_W]) * PP_W'(u2_in);
      pw_lo <= PP_W'(p_in[HALF_W-1:0]) * PP_W'(u2_in);
      n1    <= N_W'(n_prod >> coef.shift);
      // stage 2: power recombine, top digit
      sum2  <= sum1;
      u2_2  <= u2_1;
      p2    <= pw_full[FULL_W-1:U2_W];
      q2_2  <= d2.q;
      r2    <= d2.r;
      n_lo2 <= n1[2*DIG_W-1:0];
      // stage 3: middle digit
      sum3  <= sum2;
      u2_3  <= u2_2;
      p3    <= p2;
      q2_3  <= q2_2;
      q1_3  <= d1.q;
      r3    <= d1.r;
      n_lo3 <= n_lo2[DIG_W-1:0];
      // stage 4: low digit; the quotient is at most the power itself
      sum_out <= sum3;
      u2_out  <= u2_3;
      p_out   <= p3;
      t_out   <= quot[P_W-1:0];
    end
  end

endmodule

`default_nettype wire

>>> rtl/asu_checker.sv
// Port-level checks for arcsin_series_unit_core, attached by bind.
// Depends on arcsin_series_unit_core_defines.svh for the assertion macros.
`default_nettype none
`include "arcsin_series_unit_core_defines.svh"

module asu_checker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire logic signed [15:0] angle_sine,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire logic signed [15:0] angle
);

  // a held result beat keeps its value
  `ASU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(angle))

  // out_valid is low straight after reset
  `ASU_ASSERT_NOW(a_clean_reset, $past(rst), !out_valid)

  // input only backs up once the output side is holding a beat
  `ASU_ASSERT_NOW(a_block_cause, !in_ready, out_valid)

  // results stay within +-pi/2
  `ASU_ASSERT_NOW(a_range, out_valid, angle >= -16'sd25736 && angle <= 16'sd25736)

endmodule

bind arcsin_series_unit_core asu_checker u_asu_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .angle_sine (angle_sine),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .angle      (angle)
);

`default_nettype wire

>>> sim/tb_top.sv
// Self-checking testbench for arcsin_series_unit_core (Q2.14 arcsine series).
// Needs asu_pkg for the port widths; the expected angles come from a local
// bit-exact model of the truncated Maclaurin series.
`timescale 1ns / 100ps

module tb_top;

  localparam int XW           = asu_pkg::X_W;
  localparam int NTERMS       = asu_pkg::TERM_COUNT;
  localparam int TERM_CAP     = 8;
  localparam int HOLD_CYCLES  = 200;
  localparam int STALL_LIMIT  = 1500;
  localparam int DRAIN_CYCLES = 4 * NTERMS + 12;
  localparam int RAND_A       = 200;
  localparam int PRESS_ITEMS  = 80;
  localparam int RAND_B       = 250;
  localparam int N_DIRECTED   = 22;

  typedef logic signed [XW-1:0] q14_t;

  typedef struct packed {
    q14_t arg;
    logic fixed;  // want column typed in rather than predicted
    q14_t want;
  } dir_row_t;

  typedef struct packed {
    q14_t arg;
    q14_t angle;
  } angle_exp_t;

  // series coefficients (2n)! / (4^n (n!)^2 (2n+1)) as ratios
  localparam bit [63:0] SER_NUM [TERM_CAP] = '{64'd1, 64'd1, 64'd3, 64'd5,
                                               64'd35, 64'd63, 64'd231, 64'd143};
  localparam bit [63:0] SER_DEN [TERM_CAP] = '{64'd1, 64'd6, 64'd40, 64'd112,
                                               64'd1152, 64'd2816, 64'd13312,
                                               64'd10240};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  q14_t angle_sine = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  q14_t angle;

  angle_exp_t pending_angles[$];
  int  errors      = 0;
  int  sent        = 0;
  int  checked     = 0;
  bit  tx_no_idle  = 1'b0;
  bit  rx_no_idle  = 1'b0;
  bit  hold_req    = 1'b0;
  bit  held        = 1'b0;

  dir_row_t dir_rows [N_DIRECTED] = '{
    '{16'sd0,      1'b1, 16'sd0},
    '{16'sd16384,  1'b1, 16'sd25736},
    '{16'sd32767,  1'b1, 16'sd25736},
    '{16'sh8000,   1'b1, -16'sd25736},
    '{-16'sd16384, 1'b1, -16'sd25736},
    '{16'sd20000,  1'b1, 16'sd25736},
    '{-16'sd20001, 1'b1, -16'sd25736},
    '{16'sd16383,  1'b0, 16'sd0},
    '{-16'sd16383, 1'b0, 16'sd0},
    '{16'sd1,      1'b0, 16'sd0},
    '{-16'sd1,     1'b0, 16'sd0},
    '{16'sd2,      1'b0, 16'sd0},
    '{16'sd8192,   1'b0, 16'sd0},
    '{-16'sd8192,  1'b0, 16'sd0},
    '{16'sd11585,  1'b0, 16'sd0},
    '{-16'sd11585, 1'b0, 16'sd0},
    '{16'sd4096,   1'b0, 16'sd0},
    '{-16'sd4096,  1'b0, 16'sd0},
    '{16'sd14000,  1'b0, 16'sd0},
    '{-16'sd14000, 1'b0, 16'sd0},
    '{16'sh2AAA,   1'b0, 16'sd0},
    '{16'sd16000,  1'b0, 16'sd0}
  };

  arcsin_series_unit_core i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .angle_sine (angle_sine),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .angle      (angle)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
  end

  // odd series on |x|, summed exactly in Q0.50, rounded once, sign reapplied
  function automatic q14_t arcsin_q14(input q14_t x);
    int          xi;
    bit          neg;
    bit [63:0]   u;
    bit [63:0]   u2;
    bit [63:0]   pw;
    bit [63:0]   total;
    bit [63:0]   mag;
    bit [127:0]  prod;
    xi  = x;
    neg = xi < 0;
    if (xi >= 16384 || xi <= -16384) begin
      mag = 64'd25736;
    end else begin
      u     = neg ? 64'(-xi) : 64'(xi);
      u2    = u * u;
      pw    = u << 36;
      total = 64'd0;
      for (int k = 0; k < NTERMS && k < TERM_CAP; k++) begin
        total = total + (pw * SER_NUM[k]) / SER_DEN[k];
        prod  = 128'(pw) * 128'(u2);
        pw    = 64'(prod >> 28);
      end
      mag = (total + (64'd1 << 35)) >> 36;
      if (mag > 64'd25736) mag = 64'd25736;
    end
    return neg ? -q14_t'(mag) : q14_t'(mag);
  endfunction

  function automatic q14_t rand_arg();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7)
      return q14_t'($urandom_range(0, 32766) - 16383);
    else if (r == 7)
      return q14_t'(($urandom_range(0, 1) ? 16384 : -16384) + $urandom_range(0, 8) - 4);
    else
      return q14_t'($urandom);
  endfunction

  task automatic report(input string what, input q14_t arg, input q14_t got,
                        input q14_t want);
    errors++;
    $display("tb_top: %s arg=%0d got=%0d want=%0d", what, arg, got, want);
  endtask

  task automatic send_arg(input q14_t arg, input q14_t want);
    int gap;
    gap = tx_no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    angle_sine <= arg;
    do @(posedge clk); while (!in_ready);
    pending_angles.push_back('{arg: arg, angle: want});
    sent++;
  endtask

  // sender
  initial begin
    do @(posedge clk); while (rst);

    foreach (dir_rows[i])
      send_arg(dir_rows[i].arg,
               dir_rows[i].fixed ? dir_rows[i].want : arcsin_q14(dir_rows[i].arg));

    for (int i = 0; i < RAND_A; i++) begin
      tx_no_idle = (i >= 100 && i < 140);
      rx_no_idle = tx_no_idle;
      begin
        q14_t a;
        a = rand_arg();
        send_arg(a, arcsin_q14(a));
      end
    end
    tx_no_idle = 1'b0;
    rx_no_idle = 1'b0;

    // back-to-back beats into a stalled receiver: pipeline fills, in_ready drops
    hold_req   = 1'b1;
    tx_no_idle = 1'b1;
    for (int i = 0; i < PRESS_ITEMS; i++) begin
      q14_t a;
      a = rand_arg();
      send_arg(a, arcsin_q14(a));
    end
    tx_no_idle = 1'b0;

    in_valid <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk);

    for (int i = 0; i < RAND_B; i++) begin
      q14_t a;
      a = rand_arg();
      send_arg(a, arcsin_q14(a));
    end
    in_valid <= 1'b0;

    while (pending_angles.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb_top: %0d arguments sent (%0d directed), %0d angles checked, %0d mismatches",
             sent, N_DIRECTED, checked, errors);
    $display("tb_top: saturation at +-1.0, full 16-bit range, long output hold-off %0s",
             held ? "with input back-pressure" : "not reached");
    if (errors == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

  // receiver and checker
  initial begin
    int         gap;
    angle_exp_t exp_beat;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_req) begin
        gap      = HOLD_CYCLES;
        hold_req = 1'b0;
        held     = 1'b1;
      end else begin
        gap = rx_no_idle ? 0 : $urandom_range(0, 9);
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (pending_angles.size() == 0) begin
        report("unexpected beat", 'x, angle, 'x);
      end else begin
        exp_beat = pending_angles.pop_front();
        checked++;
        if (angle !== exp_beat.angle)
          report("angle mismatch", exp_beat.arg, angle, exp_beat.angle);
      end
    end
  end

  // watchdog: any beat on either channel restarts the count
  initial begin
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        idle = 0;
      else
        idle++;
    end
    $display("tb_top: no beat for %0d cycles, %0d angles outstanding",
             STALL_LIMIT, pending_angles.size());
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
